[sv/hpf_pkg.sv]
package hpf_pkg;

   // Number format and coordinate range.
   localparam int FRAC_BITS   = 16;
   localparam int COORD_BITS  = 32;

   // Field widths fixed by the interface.
   localparam int CRD_FIELD_W = 32;
   localparam int FUNC_W      = 2;
   localparam int CHAIN_W     = 8;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int K_W         = 32;
   localparam int REST_W      = 31;
   localparam int ACC_W       = 48;
   localparam int AMAG_W      = 47;
   localparam int EN_W        = 48;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 3;

   // Derived datapath widths.
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int MAG_W    = COORD_BITS + 1;
   localparam int SUM_W    = 2 * MAG_W;
   localparam int LEN_W    = COORD_BITS + 1;
   localparam int AS_W     = (LEN_W > REST_W) ? LEN_W : REST_W;
   localparam int KEFF_W   = K_W + WEIGHT_W - WEIGHT_FRAC;
   localparam int KS_W     = KEFF_W + AS_W;
   localparam int KS_LO_W  = KS_W / 2;
   localparam int KS_HI_W  = KS_W - KS_LO_W;
   localparam int TA_W     = KS_W + K_W;
   localparam int TE_W     = KS_W + AS_W;
   localparam int AM_LO_W  = AMAG_W / 2;
   localparam int AM_HI_W  = AMAG_W - AM_LO_W;
   localparam int DVD_W    = AMAG_W + MAG_W;

   // Edges from an accepted item to the edge at which its result is taken.
   localparam int PIPE_LAT = LEN_W + AMAG_W + 12;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BOND,
      FUNC_CONTACT,
      FUNC_OVERLAP,
      FUNC_HALO
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOND_K,
      CSR_CONTACT_K,
      CSR_INV_MASS,
      CSR_REST_LEN,
      CSR_CONTACTS_EN
   } csr_idx_type;

   typedef struct packed {
      func_type                       func;
      logic signed [CRD_FIELD_W-1:0]  first_x;
      logic signed [CRD_FIELD_W-1:0]  first_y;
      logic signed [CRD_FIELD_W-1:0]  first_z;
      logic signed [CRD_FIELD_W-1:0]  second_x;
      logic signed [CRD_FIELD_W-1:0]  second_y;
      logic signed [CRD_FIELD_W-1:0]  second_z;
      logic [CHAIN_W-1:0]             first_chain;
      logic [CHAIN_W-1:0]             second_chain;
      logic [WEIGHT_W-1:0]            weight;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] accel_x;
      logic signed [ACC_W-1:0] accel_y;
      logic signed [ACC_W-1:0] accel_z;
      logic [EN_W-1:0]         energy;
      logic                    force_active;
      logic                    apply_second;
      logic                    saturated;
   } rsp_type;

   // Geometry carried through the square root stages.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] ad;
      logic [2:0]            dneg;
      logic [KEFF_W-1:0]     keff;
      func_type              func;
      logic                  chain_eq;
   } geo_type;

   // Pair state between the square root and the axis products.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] ad;
      logic [2:0]            dneg;
      logic                  sneg;
      logic                  act;
      logic                  second;
      logic                  wen;
      logic [LEN_W-1:0]      len;
      logic [AS_W-1:0]       as;
      logic [KEFF_W-1:0]     keff;
   } mid_type;

   // Side data that waits beside the dividers.
   typedef struct packed {
      logic [2:0]      dneg;
      logic            sneg;
      logic            act;
      logic            second;
      logic            len_zero;
      logic [EN_W-1:0] energy;
      logic            sat;
   } tail_type;

endpackage

[sv/harmonic_pair_force.sv]
// Channel   Ports                         Transfer
// --------  ----------------------------  ------------------------------------------
// request   start, busy, req_item         start high and busy low at a rising edge
// result    rsp_valid, rsp_item           rsp_valid high for one cycle, always taken
// control   csr_we, csr_idx, csr_wdata    csr_we high at a rising edge
//
// A new pair can be taken on every clock cycle outside reset. Each result passes one bit per stage
// of the length square root (33 stages) and one quotient bit per stage of the
// three axis dividers (47 stages), with twelve further stages of difference,
// multiply and output.
// Reset is synchronous, clears the valid bits and control registers and sets
// the contacts enable. busy follows reset, so nothing is taken while reset is
// high. The result side cannot push back, so the pipeline never stalls.

module harmonic_pair_force (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  hpf_pkg::req_type               req_item,
   output logic                           rsp_valid,
   output hpf_pkg::rsp_type               rsp_item,
   input  logic                           csr_we,
   input  logic [hpf_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [hpf_pkg::CSR_W-1:0]      csr_wdata
);
   import hpf_pkg::*;

   // Sign-extend the low COORD_BITS of a coordinate so that a difference fits.
   function automatic logic signed [DIFF_W-1:0] coord_ext(
      input logic [CRD_FIELD_W-1:0] raw
   );
      return DIFF_W'($signed(raw[COORD_BITS-1:0]));
   endfunction

   // ------------------------------------------------------------------
   // Control registers. They must only be written by the user while no pair is in flight; the block does not check.
   // ------------------------------------------------------------------
   logic [K_W-1:0]    csr_bond_k_ff;
   logic [K_W-1:0]    csr_contact_k_ff;
   logic [K_W-1:0]    csr_inv_mass_ff;
   logic [REST_W-1:0] csr_rest_ff;
   logic              csr_contacts_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bond_k_ff      <= '0;
         csr_contact_k_ff   <= '0;
         csr_inv_mass_ff    <= '0;
         csr_rest_ff        <= '0;
         csr_contacts_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_BOND_K:      csr_bond_k_ff      <= csr_wdata[K_W-1:0];
            CSR_CONTACT_K:   csr_contact_k_ff   <= csr_wdata[K_W-1:0];
            CSR_INV_MASS:    csr_inv_mass_ff    <= csr_wdata[K_W-1:0];
            CSR_REST_LEN:    csr_rest_ff        <= csr_wdata[REST_W-1:0];
            CSR_CONTACTS_EN: csr_contacts_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // ------------------------------------------------------------------
   // Stage 0: capture the pair.
   // ------------------------------------------------------------------
   logic    v0_ff;
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      req_ff <= req_item;
   end

   // ------------------------------------------------------------------
   // Stage 1: coordinate differences, their magnitudes and the effective
   // stiffness of the pair's mode. Contact stiffness is scaled by the weight.
   // ------------------------------------------------------------------
   logic [2:0][CRD_FIELD_W-1:0] crd_first;
   logic [2:0][CRD_FIELD_W-1:0] crd_second;
   logic signed [DIFF_W-1:0]    diff [3];
   logic [K_W+WEIGHT_W-1:0]     ck_prod;
   geo_type                     g1_in;
   geo_type                     g1_ff;
   logic                        v1_ff;

   assign crd_first  = {req_ff.first_z, req_ff.first_y, req_ff.first_x};
   assign crd_second = {req_ff.second_z, req_ff.second_y, req_ff.second_x};
   assign ck_prod    = (K_W+WEIGHT_W)'(csr_contact_k_ff) * (K_W+WEIGHT_W)'(req_ff.weight);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]       = coord_ext(crd_second[a]) - coord_ext(crd_first[a]);
         g1_in.dneg[a] = diff[a][DIFF_W-1];
         g1_in.ad[a]   = diff[a][DIFF_W-1] ? MAG_W'(-diff[a]) : MAG_W'(diff[a]);
      end
      case (req_ff.func)
         FUNC_BOND:    g1_in.keff = KEFF_W'(csr_bond_k_ff);
         FUNC_CONTACT: g1_in.keff = ck_prod[K_W+WEIGHT_W-1:WEIGHT_FRAC];
         default:      g1_in.keff = KEFF_W'(csr_contact_k_ff);
      endcase
      g1_in.func     = req_ff.func;
      g1_in.chain_eq = req_ff.first_chain == req_ff.second_chain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      g1_ff <= g1_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: squares. Stage 3: sum of squares.
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] sq2_ff [3];
   geo_type          g2_ff;
   logic             v2_ff;
   logic [SUM_W-1:0] n3_ff;
   geo_type          g3_ff;
   logic             v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      for (int a = 0; a < 3; a++) begin
         sq2_ff[a] <= SUM_W'(g1_ff.ad[a]) * SUM_W'(g1_ff.ad[a]);
      end
      g2_ff <= g1_ff;
      n3_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      g3_ff <= g2_ff;
   end

   // ------------------------------------------------------------------
   // Square root, one root bit per stage. The remainder holds n - root^2;
   // setting bit B raises root^2 by (2*root + 2^B) * 2^B.
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] sr_rem_ff  [LEN_W-1];
   logic [SUM_W-1:0] sr_rem_in  [LEN_W-1];
   logic [LEN_W-1:0] sr_root_ff [LEN_W];
   logic [LEN_W-1:0] sr_root_in [LEN_W];
   geo_type          sr_geo_ff  [LEN_W];
   logic             sr_v_ff    [LEN_W];

   for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
      localparam int B = LEN_W - 1 - k;
      logic [SUM_W-1:0] rem_src;
      logic [LEN_W-1:0] root_src;
      logic [LEN_W:0]   base;
      logic [SUM_W:0]   delta;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_src  = n3_ff;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = sr_rem_ff[k-1];
         assign root_src = sr_root_ff[k-1];
      end

      assign base          = {root_src, 1'b0} | ((LEN_W+1)'(1) << B);
      assign delta         = (SUM_W+1)'(base) << B;
      assign take          = {1'b0, rem_src} >= delta;
      assign sr_root_in[k] = take ? (root_src | (LEN_W'(1) << B)) : root_src;

      if (k < LEN_W - 1) begin : g_rem
         assign sr_rem_in[k] = take ? rem_src - delta[SUM_W-1:0] : rem_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEN_W; k++) begin
            sr_v_ff[k] <= 1'b0;
         end
      end else begin
         sr_v_ff[0] <= v3_ff;
         for (int k = 1; k < LEN_W; k++) begin
            sr_v_ff[k] <= sr_v_ff[k-1];
         end
      end
      sr_geo_ff[0] <= g3_ff;
      for (int k = 1; k < LEN_W; k++) begin
         sr_geo_ff[k] <= sr_geo_ff[k-1];
      end
      for (int k = 0; k < LEN_W; k++) begin
         sr_root_ff[k] <= sr_root_in[k];
      end
      for (int k = 0; k < LEN_W - 1; k++) begin
         sr_rem_ff[k] <= sr_rem_in[k];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: stretch against the rest length and the mode decision.
   // Repulsion modes act only while the beads overlap, contacts only within
   // one chain and while enabled. The halo form leaves the second bead alone.
   // ------------------------------------------------------------------
   geo_type         g4;
   logic [AS_W:0]   sdiff;
   mid_type         m4_in;
   mid_type         m4_ff;
   logic            v4_ff;

   assign g4    = sr_geo_ff[LEN_W-1];
   assign sdiff = (AS_W+1)'(sr_root_ff[LEN_W-1]) - (AS_W+1)'(csr_rest_ff);

   always_comb begin
      m4_in.ad   = g4.ad;
      m4_in.dneg = g4.dneg;
      m4_in.keff = g4.keff;
      m4_in.len  = sr_root_ff[LEN_W-1];
      m4_in.sneg = sdiff[AS_W];
      m4_in.as   = sdiff[AS_W] ? AS_W'(-sdiff) : sdiff[AS_W-1:0];
      case (g4.func)
         FUNC_BOND: begin
            m4_in.act    = 1'b1;
            m4_in.second = 1'b1;
            m4_in.wen    = 1'b1;
         end
         FUNC_CONTACT: begin
            m4_in.act    = csr_contacts_en_ff && g4.chain_eq;
            m4_in.second = 1'b1;
            m4_in.wen    = 1'b1;
         end
         FUNC_OVERLAP: begin
            m4_in.act    = sdiff[AS_W];
            m4_in.second = 1'b1;
            m4_in.wen    = 1'b0;
         end
         default: begin
            m4_in.act    = sdiff[AS_W];
            m4_in.second = 1'b0;
            m4_in.wen    = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Stages 5 to 7: k*|s|, then its products with the inverse mass and with
   // |s|, each split in two halves that stage 7 sums.
   // ------------------------------------------------------------------
   logic [KS_W-1:0]         ks5_ff;
   mid_type                 m5_ff;
   logic                    v5_ff;
   logic [KS_LO_W+K_W-1:0]  pa_lo6_ff;
   logic [KS_HI_W+K_W-1:0]  pa_hi6_ff;
   logic [KS_LO_W+AS_W-1:0] pe_lo6_ff;
   logic [KS_HI_W+AS_W-1:0] pe_hi6_ff;
   mid_type                 m6_ff;
   logic                    v6_ff;
   logic [TA_W-1:0]         ta7_ff;
   logic [TE_W-1:0]         te7_ff;
   mid_type                 m7_ff;
   logic                    v7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v4_ff <= sr_v_ff[LEN_W-1];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      m4_ff     <= m4_in;
      ks5_ff    <= KS_W'(m4_ff.keff) * KS_W'(m4_ff.as);
      m5_ff     <= m4_ff;
      pa_lo6_ff <= (KS_LO_W+K_W)'(ks5_ff[KS_LO_W-1:0]) * (KS_LO_W+K_W)'(csr_inv_mass_ff);
      pa_hi6_ff <= (KS_HI_W+K_W)'(ks5_ff[KS_W-1:KS_LO_W]) * (KS_HI_W+K_W)'(csr_inv_mass_ff);
      pe_lo6_ff <= (KS_LO_W+AS_W)'(ks5_ff[KS_LO_W-1:0]) * (KS_LO_W+AS_W)'(m5_ff.as);
      pe_hi6_ff <= (KS_HI_W+AS_W)'(ks5_ff[KS_W-1:KS_LO_W]) * (KS_HI_W+AS_W)'(m5_ff.as);
      m6_ff     <= m5_ff;
      ta7_ff    <= TA_W'(pa_lo6_ff) + (TA_W'(pa_hi6_ff) << KS_LO_W);
      te7_ff    <= TE_W'(pe_lo6_ff) + (TE_W'(pe_hi6_ff) << KS_LO_W);
      m7_ff     <= m6_ff;
   end

   // ------------------------------------------------------------------
   // Stage 8: scale back to FRAC_BITS and clip. The energy carries the
   // extra halving. Only the spring modes report energy.
   // ------------------------------------------------------------------
   logic [TA_W-1:0]   ta_sh;
   logic [TE_W-1:0]   te_sh;
   logic              asat;
   logic              esat;
   logic [AMAG_W-1:0] amag8_in;
   tail_type          tl8_in;
   logic [AMAG_W-1:0] amag8_ff;
   tail_type          tl8_ff;
   mid_type           m8_ff;
   logic              v8_ff;

   assign ta_sh    = ta7_ff >> (2 * FRAC_BITS);
   assign te_sh    = te7_ff >> (2 * FRAC_BITS + 1);
   assign asat     = |ta_sh[TA_W-1:AMAG_W];
   assign esat     = m7_ff.wen && (|te_sh[TE_W-1:EN_W]);
   assign amag8_in = asat ? {AMAG_W{1'b1}} : ta_sh[AMAG_W-1:0];

   always_comb begin
      tl8_in.dneg     = m7_ff.dneg;
      tl8_in.sneg     = m7_ff.sneg;
      tl8_in.act      = m7_ff.act;
      tl8_in.second   = m7_ff.second;
      tl8_in.len_zero = m7_ff.len == '0;
      tl8_in.sat      = asat || esat;
      if (!m7_ff.wen) begin
         tl8_in.energy = '0;
      end else if (esat) begin
         tl8_in.energy = {EN_W{1'b1}};
      end else begin
         tl8_in.energy = te_sh[EN_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stages 9 and 10: |a| * |d| per axis, as two partial products.
   // ------------------------------------------------------------------
   logic [AM_LO_W+MAG_W-1:0] ax_lo9_ff [3];
   logic [AM_HI_W+MAG_W-1:0] ax_hi9_ff [3];
   tail_type                 tl9_ff;
   logic [LEN_W-1:0]         len9_ff;
   logic                     v9_ff;
   logic [DVD_W-1:0]         dvd10_ff [3];
   tail_type                 tl10_ff;
   logic [LEN_W-1:0]         len10_ff;
   logic                     v10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else begin
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
      amag8_ff <= amag8_in;
      tl8_ff   <= tl8_in;
      m8_ff    <= m7_ff;
      for (int a = 0; a < 3; a++) begin
         ax_lo9_ff[a] <= (AM_LO_W+MAG_W)'(amag8_ff[AM_LO_W-1:0]) *
                         (AM_LO_W+MAG_W)'(m8_ff.ad[a]);
         ax_hi9_ff[a] <= (AM_HI_W+MAG_W)'(amag8_ff[AMAG_W-1:AM_LO_W]) *
                         (AM_HI_W+MAG_W)'(m8_ff.ad[a]);
         dvd10_ff[a]  <= DVD_W'(ax_lo9_ff[a]) + (DVD_W'(ax_hi9_ff[a]) << AM_LO_W);
      end
      tl9_ff   <= tl8_ff;
      len9_ff  <= m8_ff.len;
      tl10_ff  <= tl9_ff;
      len10_ff <= len9_ff;
   end

   // ------------------------------------------------------------------
   // Per-axis division by L. Since |d| <= L on every axis, each quotient is
   // no larger than |a|. The side data waits in a chain of equal depth.
   // ------------------------------------------------------------------
   logic [2:0][AMAG_W-1:0] quo;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      hpf_div u_div (
         .clock (clock),
         .dvd   (dvd10_ff[a]),
         .dsr   (len10_ff),
         .quo   (quo[a])
      );
   end

   tail_type tl_ff   [AMAG_W];
   logic     tl_v_ff [AMAG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AMAG_W; k++) begin
            tl_v_ff[k] <= 1'b0;
         end
      end else begin
         tl_v_ff[0] <= v10_ff;
         for (int k = 1; k < AMAG_W; k++) begin
            tl_v_ff[k] <= tl_v_ff[k-1];
         end
      end
      tl_ff[0] <= tl10_ff;
      for (int k = 1; k < AMAG_W; k++) begin
         tl_ff[k] <= tl_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // Output: apply the sign of s times the sign of d on each axis. With
   // coincident beads every axis is zero. A pair that does not act gives
   // an all-zero result.
   // ------------------------------------------------------------------
   tail_type                      tf;
   logic [2:0][ACC_W-1:0]         acc;
   logic [ACC_W-1:0]              cx [3];
   rsp_type                       rsp_in;
   rsp_type                       rsp_item_ff;
   logic                          rsp_valid_ff;

   assign tf = tl_ff[AMAG_W-1];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cx[a]  = tf.len_zero ? '0 : ACC_W'(quo[a]);
         acc[a] = (tf.sneg ^ tf.dneg[a]) ? -cx[a] : cx[a];
      end
      if (tf.act) begin
         rsp_in.accel_x      = acc[0];
         rsp_in.accel_y      = acc[1];
         rsp_in.accel_z      = acc[2];
         rsp_in.energy       = tf.energy;
         rsp_in.force_active = 1'b1;
         rsp_in.apply_second = tf.second;
         rsp_in.saturated    = tf.sat;
      end else begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tl_v_ff[AMAG_W-1];
      end
      rsp_item_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[sv/hpf_div.sv]
module hpf_div (
   input  logic                        clock,
   input  logic [hpf_pkg::DVD_W-1:0]  dvd,
   input  logic [hpf_pkg::LEN_W-1:0]  dsr,
   output logic [hpf_pkg::AMAG_W-1:0] quo
);
   import hpf_pkg::*;

   // Restoring division, one quotient bit per stage, most significant first.
   // The quotient is known to fit in AMAG_W bits.
   logic [DVD_W-1:0]  rem_ff [AMAG_W-1];
   logic [DVD_W-1:0]  rem_in [AMAG_W-1];
   logic [LEN_W-1:0]  dsr_ff [AMAG_W-1];
   logic [AMAG_W-1:0] quo_ff [AMAG_W];
   logic [AMAG_W-1:0] quo_in [AMAG_W];

   for (genvar k = 0; k < AMAG_W; k++) begin : g_stage
      localparam int B = AMAG_W - 1 - k;
      logic [DVD_W-1:0]  rem_src;
      logic [LEN_W-1:0]  dsr_src;
      logic [AMAG_W-1:0] quo_src;
      logic [DVD_W-1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_src = dvd;
         assign dsr_src = dsr;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign dsr_src = dsr_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign trial     = DVD_W'(dsr_src) << B;
      assign take      = rem_src >= trial;
      assign quo_in[k] = quo_src | (take ? (AMAG_W'(1) << B) : '0);

      if (k < AMAG_W - 1) begin : g_rem
         assign rem_in[k] = take ? rem_src - trial : rem_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < AMAG_W; k++) begin
         quo_ff[k] <= quo_in[k];
      end
      for (int k = 0; k < AMAG_W - 1; k++) begin
         rem_ff[k] <= rem_in[k];
      end
      dsr_ff[0] <= dsr;
      for (int k = 1; k < AMAG_W - 1; k++) begin
         dsr_ff[k] <= dsr_ff[k-1];
      end
   end

   assign quo = quo_ff[AMAG_W-1];

endmodule

[sv/hpf_checker.sv]
module hpf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input hpf_pkg::rsp_type rsp_item
);
   import hpf_pkg::*;

   // Reset empties the pipeline, so no result follows a reset cycle.
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // Every result belongs to a pair taken a fixed number of cycles earlier.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("result without a matching request");

   // A pair that gives no force gives an all-zero result.
   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.force_active |->
         rsp_item.accel_x == '0 && rsp_item.accel_y == '0 &&
         rsp_item.accel_z == '0 && rsp_item.energy == '0 &&
         !rsp_item.apply_second && !rsp_item.saturated)
      else $error("inactive pair with nonzero result");

   // Energy comes only from the spring modes, which act on both beads.
   a_energy_spring : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.energy != '0 |->
         rsp_item.force_active && rsp_item.apply_second)
      else $error("energy reported outside a spring mode");

endmodule

bind harmonic_pair_force hpf_checker u_checker (.*);
